>>> rtl/core/text_console_glyph_emitter_unit_macros.svh
// Assertion macros shared by the console emitter modules.
`ifndef TEXT_CONSOLE_GLYPH_EMITTER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_EMITTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCGE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcge check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcge check failed");

`endif

>>> rtl/core/tcge_pkg.sv
package tcge_pkg;

  // Fixed cell width and screen position limits.
  localparam int GLYPH_WIDTH = 8;
  localparam logic [12:0] POS_MAX = 13'd8191;

  // Special character codes.
  localparam logic [7:0] CODE_NUL = 8'd0;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_NL  = 8'd10;

  // Input functions.
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_FORE_COLOR    = 3'd2;
  localparam logic [2:0] CFG_BACK_COLOR    = 3'd3;
  localparam logic [2:0] CFG_ERASE_COLOR   = 3'd4;

  // Configuration reset values.
  localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
  localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
  localparam logic [31:0] RST_FORE_COLOR    = 32'hFFFF_FFFF;
  localparam logic [31:0] RST_BACK_COLOR    = 32'h0000_0000;
  localparam logic [31:0] RST_ERASE_COLOR   = 32'h0000_0000;

  // Result kinds.
  localparam logic [1:0] KIND_GLYPH  = 2'd0;
  localparam logic [1:0] KIND_ERASE  = 2'd1;
  localparam logic [1:0] KIND_SCREEN = 2'd2;

  // Span bit patterns.
  localparam logic [7:0] SPAN_FULL  = 8'hFF;
  localparam logic [7:0] SPAN_EMPTY = 8'h00;

  // Queue depth between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Operations handed from the front to the back.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ERASE = 2'd1,
    OP_GLYPH = 2'd2
  } op_t;

  // One command for the back part.
  typedef struct packed {
    op_t         op;
    logic        clear;
    logic        blank;
    logic [12:0] x;
    logic [12:0] y;
    logic [7:0]  code;
    logic [3:0]  ridx;
    logic [7:0]  pat;
  } cmd_t;

  // A command together with its valid flag.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_word_t;

  // Colors used by the back part.
  typedef struct packed {
    logic [31:0] fore;
    logic [31:0] back;
    logic [31:0] erase;
  } colors_t;

endpackage

>>> rtl/core/tcge_queue.sv
`include "text_console_glyph_emitter_unit_macros.svh"

module tcge_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tcge_pkg::cmd_word_t push,
  output logic               full,
  output tcge_pkg::cmd_word_t head,
  input  logic               pop
);

  localparam int PW = $clog2(tcge_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(tcge_pkg::QUEUE_DEPTH + 1);

  tcge_pkg::cmd_t entry_r [tcge_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign full       = (cnt_r == CW'(tcge_pkg::QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(tcge_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(tcge_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.valid && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.cmd;
    end
  end

  // The front only pushes when there is room, and the back only pops a held word.
  `TCGE_ASSERT_NOW(a_no_push_full, clk, rst_n, push.valid, !full || do_pop)
  `TCGE_ASSERT_NOW(a_pop_held, clk, rst_n, pop, head.valid)

endmodule

>>> rtl/core/tcge_front.sv
module tcge_front #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [7:0]          in_char_code,
  input  logic [3:0]          in_row_index,
  input  logic [7:0]          in_row_pattern,
  input  logic [12:0]         screen_width,
  input  logic [12:0]         screen_height,
  input  logic                q_full,
  output tcge_pkg::cmd_word_t push
);

  localparam logic [13:0] ROWS14 = 14'(GLYPH_ROWS);
  localparam logic [13:0] CELL14 = 14'(tcge_pkg::GLYPH_WIDTH);

  logic [12:0] cursor_col_r, cursor_col_nxt;
  logic [12:0] cursor_row_r, cursor_row_nxt;
  logic        accept;
  logic        load_ok;
  logic        blank;

  // Backspace path.
  logic        bs_wrap;
  logic [12:0] bs_col, bs_row, bs_x;

  // Printable path.
  logic [13:0] pr_right, pr_down, pr_bottom, pr_adv;
  logic        pr_wrap, pr_clear;
  logic [12:0] pr_col1, pr_row1, pr_col, pr_row, pr_col_new;

  // Saturate a 14-bit position sum to the cursor range.
  function automatic logic [12:0] sat_pos(input logic [13:0] v);
    logic [12:0] r;
    r = (v > 14'(tcge_pkg::POS_MAX)) ? tcge_pkg::POS_MAX : v[12:0];
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign load_ok  = (32'(in_row_index) < 32'(GLYPH_ROWS)) &&
                    (32'(in_char_code) < 32'(GLYPH_COUNT));
  assign blank    = (32'(in_char_code) >= 32'(GLYPH_COUNT));

  // Backspace steps back a cell, wrapping to the end of the previous line.
  always_comb begin
    bs_wrap = (cursor_col_r < 13'(tcge_pkg::GLYPH_WIDTH));
    bs_col  = bs_wrap ? screen_width : cursor_col_r;
    if (bs_wrap) begin
      bs_row = (cursor_row_r >= 13'(GLYPH_ROWS)) ? cursor_row_r - 13'(GLYPH_ROWS) : '0;
    end else begin
      bs_row = cursor_row_r;
    end
    bs_x = (bs_col >= 13'(tcge_pkg::GLYPH_WIDTH)) ?
           bs_col - 13'(tcge_pkg::GLYPH_WIDTH) : '0;
  end

  // Printable codes wrap at the right edge and home at the bottom edge.
  always_comb begin
    pr_right   = {1'b0, cursor_col_r} + CELL14;
    pr_wrap    = (pr_right > {1'b0, screen_width});
    pr_down    = {1'b0, cursor_row_r} + ROWS14;
    pr_col1    = pr_wrap ? '0 : cursor_col_r;
    pr_row1    = pr_wrap ? sat_pos(pr_down) : cursor_row_r;
    pr_bottom  = {1'b0, pr_row1} + ROWS14;
    pr_clear   = (pr_bottom > {1'b0, screen_height});
    pr_col     = pr_clear ? '0 : pr_col1;
    pr_row     = pr_clear ? '0 : pr_row1;
    pr_adv     = {1'b0, pr_col} + CELL14;
    pr_col_new = sat_pos(pr_adv);
  end

  // Classify the word and build the command for the back part.
  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    push.valid     = 1'b0;
    push.cmd.op    = tcge_pkg::OP_GLYPH;
    push.cmd.clear = 1'b0;
    push.cmd.blank = blank;
    push.cmd.x     = pr_col;
    push.cmd.y     = pr_row;
    push.cmd.code  = in_char_code;
    push.cmd.ridx  = in_row_index;
    push.cmd.pat   = in_row_pattern;
    if (accept) begin
      if (in_func == tcge_pkg::FUNC_LOAD) begin
        push.valid  = load_ok;
        push.cmd.op = tcge_pkg::OP_LOAD;
      end else begin
        case (in_char_code)
          tcge_pkg::CODE_NUL: begin
          end
          tcge_pkg::CODE_NL: begin
            cursor_col_nxt = '0;
            cursor_row_nxt = sat_pos({1'b0, cursor_row_r} + ROWS14);
          end
          tcge_pkg::CODE_BS: begin
            push.valid     = 1'b1;
            push.cmd.op    = tcge_pkg::OP_ERASE;
            push.cmd.x     = bs_x;
            push.cmd.y     = bs_row;
            cursor_col_nxt = bs_x;
            cursor_row_nxt = bs_row;
          end
          default: begin
            push.valid     = 1'b1;
            push.cmd.clear = pr_clear;
            cursor_col_nxt = pr_col_new;
            cursor_row_nxt = pr_row;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

endmodule

>>> rtl/core/tcge_back.sv
`include "text_console_glyph_emitter_unit_macros.svh"

module tcge_back #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tcge_pkg::cmd_word_t head,
  output logic                pop,
  input  tcge_pkg::colors_t   colors,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [11:0]         out_pix_x,
  output logic [12:0]         out_pix_y,
  output logic [7:0]          out_span_bits,
  output logic [31:0]         out_on_color,
  output logic [31:0]         out_off_color,
  output logic                out_last
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GLYPH_ROWS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_SPAN  = 3'b100
  } state_t;

  state_t         state_r, state_nxt;
  tcge_pkg::cmd_t cur_r, cur_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           row_last;
  logic           adv;

  // Font memory and its read port.
  logic [7:0]     font_mem [DEPTH];
  logic [7:0]     rdata_r;
  logic           mem_we;
  logic [AW-1:0]  waddr, raddr;
  logic [7:0]     code_sel;

  // Output register.
  logic           out_valid_r, out_valid_nxt;
  logic           load_out;
  logic [1:0]     kind_r, kind_nxt;
  logic [11:0]    pix_x_r, pix_x_nxt;
  logic [12:0]    pix_y_r, pix_y_nxt;
  logic [7:0]     bits_r, bits_nxt;
  logic [31:0]    on_r, on_nxt;
  logic [31:0]    off_r, off_nxt;
  logic           last_r, last_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign row_last = (row_r == RW'(GLYPH_ROWS - 1));
  assign pop      = (state_r == ST_IDLE) && head.valid;

  // Sequencer: take a command, then emit its spans one per free output slot.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    row_nxt   = row_r;
    mem_we    = 1'b0;
    load_out  = 1'b0;
    kind_nxt  = kind_r;
    pix_x_nxt = pix_x_r;
    pix_y_nxt = pix_y_r;
    bits_nxt  = bits_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          cur_nxt = head.cmd;
          row_nxt = '0;
          if (head.cmd.op == tcge_pkg::OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            state_nxt = head.cmd.clear ? ST_CLEAR : ST_SPAN;
          end
        end
      end
      ST_CLEAR: begin
        if (adv) begin
          load_out  = 1'b1;
          kind_nxt  = tcge_pkg::KIND_SCREEN;
          pix_x_nxt = '0;
          pix_y_nxt = '0;
          bits_nxt  = tcge_pkg::SPAN_EMPTY;
          on_nxt    = colors.erase;
          off_nxt   = colors.erase;
          last_nxt  = 1'b0;
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        if (adv) begin
          load_out  = 1'b1;
          pix_x_nxt = cur_r.x[11:0];
          pix_y_nxt = cur_r.y + 13'(row_r);
          last_nxt  = row_last;
          if (cur_r.op == tcge_pkg::OP_ERASE) begin
            kind_nxt = tcge_pkg::KIND_ERASE;
            bits_nxt = tcge_pkg::SPAN_FULL;
            on_nxt   = colors.erase;
            off_nxt  = colors.erase;
          end else begin
            kind_nxt = tcge_pkg::KIND_GLYPH;
            bits_nxt = cur_r.blank ? tcge_pkg::SPAN_EMPTY : rdata_r;
            on_nxt   = colors.fore;
            off_nxt  = colors.back;
          end
          if (row_last) begin
            state_nxt = ST_IDLE;
            row_nxt   = '0;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = adv ? load_out : out_valid_r;
  end

  // The read address always follows the row that is emitted next.
  assign code_sel = pop ? head.cmd.code : cur_r.code;
  assign raddr    = AW'(32'(code_sel) * 32'(GLYPH_ROWS) + 32'(row_nxt));
  assign waddr    = AW'(32'(head.cmd.code) * 32'(GLYPH_ROWS) + 32'(head.cmd.ridx));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      font_mem[waddr] <= head.cmd.pat;
    end
    rdata_r <= font_mem[raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    kind_r  <= kind_nxt;
    pix_x_r <= pix_x_nxt;
    pix_y_r <= pix_y_nxt;
    bits_r  <= bits_nxt;
    on_r    <= on_nxt;
    off_r   <= off_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_pix_x     = pix_x_r;
  assign out_pix_y     = pix_y_r;
  assign out_span_bits = bits_r;
  assign out_on_color  = on_r;
  assign out_off_color = off_r;
  assign out_last      = last_r;

  // Screen clears come only ahead of a glyph, and never end a command.
  `TCGE_ASSERT_NOW(a_clear_glyph, clk, rst_n, state_r == ST_CLEAR, cur_r.op == tcge_pkg::OP_GLYPH)
  `TCGE_ASSERT_NOW(a_screen_not_last, clk, rst_n,
    out_valid_r && (kind_r == tcge_pkg::KIND_SCREEN), !last_r)
  // After the final span of a command the sequencer is back to taking commands.
  `TCGE_ASSERT_NEXT(a_last_idle, clk, rst_n,
    (state_r == ST_SPAN) && adv && row_last, state_r == ST_IDLE)

endmodule

>>> rtl/core/text_console_glyph_emitter_unit.sv
// Channel | Direction | Handshake           | Words
// in      | input     | in_valid/in_ready   | func, char_code, row_index, row_pattern
// out     | output    | out_valid/out_ready | kind, pix_x, pix_y, span_bits, colors, last
// cfg     | input     | cfg_we              | cfg_index selects one of five registers
//
// The front takes one input word per cycle while the two-entry command queue has room.
// Code zero, newline and dropped font loads finish in the front in that cycle.
// The back takes a command while idle, then emits a span per glyph row for a glyph or
// backspace, after a screen clear span if due; a font load only writes the memory.
// A stalled output holds the back, and a full queue then holds the input side.
// Reset is synchronous; the font memory is not cleared and needs loading before use.
module text_console_glyph_emitter_unit #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_row_index,
  input  logic [7:0]  in_row_pattern,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [11:0] out_pix_x,
  output logic [12:0] out_pix_y,
  output logic [7:0]  out_span_bits,
  output logic [31:0] out_on_color,
  output logic [31:0] out_off_color,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [12:0]         screen_width_r;
  logic [12:0]         screen_height_r;
  tcge_pkg::colors_t   colors_r;
  tcge_pkg::cmd_word_t push;
  tcge_pkg::cmd_word_t head;
  logic                q_full;
  logic                pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= tcge_pkg::RST_SCREEN_WIDTH;
      screen_height_r <= tcge_pkg::RST_SCREEN_HEIGHT;
      colors_r.fore   <= tcge_pkg::RST_FORE_COLOR;
      colors_r.back   <= tcge_pkg::RST_BACK_COLOR;
      colors_r.erase  <= tcge_pkg::RST_ERASE_COLOR;
    end else if (cfg_we) begin
      case (cfg_index)
        tcge_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data[12:0];
        tcge_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data[12:0];
        tcge_pkg::CFG_FORE_COLOR:    colors_r.fore   <= cfg_data;
        tcge_pkg::CFG_BACK_COLOR:    colors_r.back   <= cfg_data;
        tcge_pkg::CFG_ERASE_COLOR:   colors_r.erase  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: cursor tracking and command building.
  tcge_front #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_char_code   (in_char_code),
    .in_row_index   (in_row_index),
    .in_row_pattern (in_row_pattern),
    .screen_width   (screen_width_r),
    .screen_height  (screen_height_r),
    .q_full         (q_full),
    .push           (push)
  );

  // Command queue between the two parts.
  tcge_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  // Back: font memory and span sequencer.
  tcge_back #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .colors        (colors_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_pix_x     (out_pix_x),
    .out_pix_y     (out_pix_y),
    .out_span_bits (out_span_bits),
    .out_on_color  (out_on_color),
    .out_off_color (out_off_color),
    .out_last      (out_last)
  );

endmodule

>>> tb/text_console_glyph_emitter_unit_test.sv
`timescale 1ns / 1ps

module text_console_glyph_emitter_unit_test;
  import tcge_pkg::*;

  localparam int GLYPH_ROWS = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;
  localparam int WORDS_PER_SETTING = 18;
  localparam logic [7:0] LEFT_PIXEL = 8'h80;

  // One span word as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] pix_x;
    logic [12:0] pix_y;
    logic [7:0]  span_bits;
    logic [31:0] on_color;
    logic [31:0] off_color;
    logic        last;
  } span_t;

  // Tracks the cursor, the font and the registers, and holds the spans still owed.
  class console_span_tracker;
    int unsigned width;
    int unsigned height;
    logic [31:0] fore;
    logic [31:0] back;
    logic [31:0] erase;
    int unsigned col;
    int unsigned row;
    logic [7:0]  font [GLYPH_COUNT * GLYPH_ROWS];
    span_t       owed_spans [$];
    int          mismatches;
    int          glyph_rows;
    int          erase_spans;
    int          screen_clears;

    function new();
      width = RST_SCREEN_WIDTH;
      height = RST_SCREEN_HEIGHT;
      fore = RST_FORE_COLOR;
      back = RST_BACK_COLOR;
      erase = RST_ERASE_COLOR;
      col = 0;
      row = 0;
      mismatches = 0;
      glyph_rows = 0;
      erase_spans = 0;
      screen_clears = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_SCREEN_WIDTH: width = data[12:0];
        CFG_SCREEN_HEIGHT: height = data[12:0];
        CFG_FORE_COLOR: fore = data;
        CFG_BACK_COLOR: back = data;
        CFG_ERASE_COLOR: erase = data;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_pos(int unsigned v);
      return (v > POS_MAX) ? POS_MAX : v;
    endfunction

    function void owe_span(logic [1:0] kind, int unsigned x, int unsigned y,
                           logic [7:0] bits, logic [31:0] on, logic [31:0] off);
      span_t s;
      s.kind = kind;
      s.pix_x = 12'(x);
      s.pix_y = 13'(y);
      s.span_bits = bits;
      s.on_color = on;
      s.off_color = off;
      s.last = 1'b0;
      owed_spans.push_back(s);
    endfunction

    function void close_burst();
      owed_spans[owed_spans.size() - 1].last = 1'b1;
    endfunction

    // Works out the spans that one accepted input word causes.
    function void take_word(logic func, logic [7:0] code, logic [3:0] ridx, logic [7:0] pat);
      int unsigned x;
      if (func == FUNC_LOAD) begin
        font[int'(code) * GLYPH_ROWS + int'(ridx)] = pat;
        return;
      end
      if (code == CODE_NUL) return;
      if (code == CODE_NL) begin
        col = 0;
        row = clamp_pos(row + GLYPH_ROWS);
        return;
      end
      // Backspace steps back one cell, wrapping to the end of the line above.
      if (code == CODE_BS) begin
        if (col < GLYPH_WIDTH) begin
          col = width;
          row = (row >= GLYPH_ROWS) ? row - GLYPH_ROWS : 0;
        end
        x = (col >= GLYPH_WIDTH) ? col - GLYPH_WIDTH : 0;
        for (int r = 0; r < GLYPH_ROWS; r++) owe_span(KIND_ERASE, x, row + r, SPAN_FULL, erase, erase);
        col = x;
        close_burst();
        return;
      end
      // Printable code: wrap at the right edge, clear and home at the bottom edge.
      if (col + GLYPH_WIDTH > width) begin
        col = 0;
        row = clamp_pos(row + GLYPH_ROWS);
      end
      if (row + GLYPH_ROWS > height) begin
        owe_span(KIND_SCREEN, 0, 0, SPAN_EMPTY, erase, erase);
        col = 0;
        row = 0;
      end
      for (int r = 0; r < GLYPH_ROWS; r++)
        owe_span(KIND_GLYPH, col, row + r, font[int'(code) * GLYPH_ROWS + r], fore, back);
      col = clamp_pos(col + GLYPH_WIDTH);
      close_burst();
    endfunction

    function void diff_field(string name, longint unsigned want, longint unsigned seen);
      if (want != seen) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
        mismatches++;
      end
    endfunction

    // Compares one accepted span word with the oldest one owed.
    function void match_span(span_t seen);
      span_t want;
      if (owed_spans.size() == 0) begin
        $error("unexpected span: kind %0d x %0d y %0d", seen.kind, seen.pix_x, seen.pix_y);
        mismatches++;
        return;
      end
      want = owed_spans.pop_front();
      diff_field("kind", want.kind, seen.kind);
      diff_field("pix_x", want.pix_x, seen.pix_x);
      diff_field("pix_y", want.pix_y, seen.pix_y);
      diff_field("span_bits", want.span_bits, seen.span_bits);
      diff_field("on_color", want.on_color, seen.on_color);
      diff_field("off_color", want.off_color, seen.off_color);
      diff_field("last", want.last, seen.last);
      if (want.kind == KIND_GLYPH) glyph_rows++;
      else if (want.kind == KIND_ERASE) erase_spans++;
      else screen_clears++;
    endfunction

    function int outstanding();
      return owed_spans.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = FUNC_PUT;
  logic [7:0]  in_char_code = CODE_NUL;
  logic [3:0]  in_row_index = 4'd0;
  logic [7:0]  in_row_pattern = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [11:0] out_pix_x;
  logic [12:0] out_pix_y;
  logic [7:0]  out_span_bits;
  logic [31:0] out_on_color;
  logic [31:0] out_off_color;
  logic        out_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_SCREEN_WIDTH;
  logic [31:0] cfg_data = 32'd0;

  console_span_tracker tracker = new();

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 70;
  int unsigned quiet_cycles = 0;
  int          words_sent = 0;
  int          loads_sent = 0;
  int          settings_used = 0;
  bit [GLYPH_ROWS-1:0] rows_loaded [GLYPH_COUNT];
  logic [7:0]  ready_glyphs [$];

  text_console_glyph_emitter_unit #(
    .GLYPH_ROWS(GLYPH_ROWS),
    .GLYPH_COUNT(GLYPH_COUNT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_char_code(in_char_code),
    .in_row_index(in_row_index),
    .in_row_pattern(in_row_pattern),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_pix_x(out_pix_x),
    .out_pix_y(out_pix_y),
    .out_span_bits(out_span_bits),
    .out_on_color(out_on_color),
    .out_off_color(out_off_color),
    .out_last(out_last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check each accepted span word and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.match_span({out_kind, out_pix_x, out_pix_y, out_span_bits,
                          out_on_color, out_off_color, out_last});
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Presents one input word and waits until it is taken.
  task automatic send_word(logic func, logic [7:0] code, logic [3:0] ridx, logic [7:0] pat);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_char_code <= code;
    in_row_index <= ridx;
    in_row_pattern <= pat;
    do @(posedge clk); while (!in_ready);
    tracker.take_word(func, code, ridx, pat);
    if (func == FUNC_LOAD) loads_sent++;
    words_sent++;
  endtask

  function automatic logic [7:0] font_pattern();
    case ($urandom_range(0, 7))
      0: return SPAN_EMPTY;
      1: return SPAN_FULL;
      2: return LEFT_PIXEL;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic load_row(logic [7:0] code, logic [3:0] ridx, logic [7:0] pat);
    send_word(FUNC_LOAD, code, ridx, pat);
    rows_loaded[code][ridx] = 1'b1;
  endtask

  // Fills in every missing row of a glyph, starting at a random row.
  task automatic load_glyph(logic [7:0] code);
    int unsigned first;
    int unsigned r;
    first = $urandom_range(0, GLYPH_ROWS - 1);
    for (int i = 0; i < GLYPH_ROWS; i++) begin
      r = (first + i) % GLYPH_ROWS;
      if (!rows_loaded[code][r]) load_row(code, 4'(r), font_pattern());
    end
    ready_glyphs.push_back(code);
  endtask

  // A printable code is only sent once all of its font rows are loaded.
  task automatic put_char(logic [7:0] code);
    if (code != CODE_NUL && code != CODE_NL && code != CODE_BS && rows_loaded[code] != '1)
      load_glyph(code);
    send_word(FUNC_PUT, code, 4'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] any_printable();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CODE_BS || c == CODE_NL);
    return c;
  endfunction

  task automatic random_word();
    int unsigned pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 15) load_row(8'($urandom), 4'($urandom), font_pattern());
    else if (pick < 24) put_char(CODE_NL);
    else if (pick < 34) put_char(CODE_BS);
    else if (pick < 38) put_char(CODE_NUL);
    else begin
      if (ready_glyphs.size() > 0 && $urandom_range(0, 3) != 0)
        c = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
      else
        c = any_printable();
      put_char(c);
    end
  endtask

  // Let the block drain so that registers can be changed safely.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers, one per cycle.
  task automatic program_regs(logic [12:0] w, logic [12:0] h,
                              logic [31:0] f, logic [31:0] b, logic [31:0] e);
    logic [2:0]  idx [5];
    logic [31:0] val [5];
    idx = '{CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_FORE_COLOR, CFG_BACK_COLOR,
            CFG_ERASE_COLOR};
    val = '{{19'd0, w}, {19'd0, h}, f, b, e};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      tracker.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int setting;
    int first_word;
    logic [7:0] sample_glyphs [4];
    sample_glyphs = '{8'h01, 8'h41, 8'h42, 8'hFF};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load a handful of glyphs and print two at the reset settings.
    foreach (sample_glyphs[i]) load_glyph(sample_glyphs[i]);
    put_char(8'h41);
    put_char(8'h42);

    // Directed part on a 2x2 cell screen: wraps, clears, backspace corners, extreme codes.
    settle();
    program_regs(13'd16, 13'd32, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_A5A5);
    put_char(CODE_NUL);
    put_char(8'h41);
    put_char(8'h42);
    put_char(8'h41);
    put_char(CODE_BS);
    put_char(CODE_BS);
    put_char(CODE_NL);
    put_char(CODE_BS);
    load_row(8'hFF, 4'd15, SPAN_FULL);
    load_row(8'h01, 4'd0, SPAN_EMPTY);
    load_row(8'h42, 4'd7, LEFT_PIXEL);
    put_char(8'hFF);
    put_char(8'h01);
    put_char(CODE_NL);
    put_char(CODE_NL);
    put_char(8'h42);

    // Random part: three handshake pressure modes, two register settings each.
    for (int mode = 0; mode < 3; mode++) begin
      if (mode == 0) begin
        send_idle_pct = 19;
        recv_idle_pct = 70;
      end else if (mode == 1) begin
        send_idle_pct = 70;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < 2; k++) begin
        setting = mode * 2 + k;
        settle();
        if (setting == 0)
          program_regs(13'd8, 13'd16, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        else if (setting == 1)
          program_regs(13'd4096, 13'd4096, $urandom, $urandom, $urandom);
        else if (setting == 3)
          program_regs(13'($urandom_range(9, 127)), 13'($urandom_range(16, 96)),
                       $urandom, $urandom, $urandom);
        else
          program_regs(13'(8 * $urandom_range(1, 16)), 13'($urandom_range(16, 96)),
                       $urandom, $urandom, $urandom);

        first_word = words_sent;
        while (words_sent - first_word < WORDS_PER_SETTING) random_word();
      end
    end

    settle();
    $display("Sent %0d input words (%0d font loads) over %0d register settings.",
             words_sent, loads_sent, settings_used);
    $display("Checked %0d glyph rows, %0d erase spans and %0d screen clears.",
             tracker.glyph_rows, tracker.erase_spans, tracker.screen_clears);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tcge_pkg.sv
rtl/core/tcge_queue.sv
rtl/core/tcge_front.sv
rtl/core/tcge_back.sv
rtl/core/text_console_glyph_emitter_unit.sv
tb/text_console_glyph_emitter_unit_test.sv
